@@ rtl/u8cu_pkg.sv @@
`default_nettype none

package u8cu_pkg;

   // Code points touched by the case mapping (11-bit two-byte range)
   localparam logic [10:0] CP_SMALL_A   = 11'h430;
   localparam logic [10:0] CP_SMALL_YA  = 11'h44F;
   localparam logic [10:0] CP_SMALL_IO  = 11'h451;
   localparam logic [10:0] CP_CAP_IO    = 11'h401;
   localparam logic [10:0] CP_SMALL_I   = 11'h456;
   localparam logic [10:0] CP_CAP_I     = 11'h406;
   localparam logic [10:0] CP_SMALL_YI  = 11'h457;
   localparam logic [10:0] CP_CAP_YI    = 11'h407;
   localparam logic [10:0] CP_SMALL_YE  = 11'h454;
   localparam logic [10:0] CP_CAP_YE    = 11'h404;
   localparam logic [10:0] CP_SMALL_GHE = 11'h491;
   localparam logic [10:0] CP_CAP_GHE   = 11'h490;
   localparam logic [10:0] CP_CASE_OFS  = 11'h020;
   localparam logic [10:0] CP_ONE_BYTE  = 11'h080;

   // Bytes of output a single request can produce
   localparam int unsigned MAX_OUT = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // Re-encoded two-byte sequence: one or two bytes
   typedef struct packed {
      logic       two;
      logic [7:0] b0;
      logic [7:0] b1;
   } pair_type;

endpackage

`default_nettype wire

@@ rtl/utf8_cyrillic_uppercase_stream_top.sv @@
// Latency: the first output byte of a request is valid the cycle after it is taken.
// Throughput: one request per cycle while each request gives at most one byte and the
//   receiver is ready; a request that gives n bytes (n up to 3, or 4 for a completed
//   four-byte sequence) holds the output until all n are read, the next request is taken as the last is read.
// Reset: synchronous, clears the held-byte count and the output buffer.
`default_nettype none

module utf8_cyrillic_uppercase_stream_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  u8cu_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output u8cu_pkg::rsp_type   rsp_data
);

   // a-z to A-Z, everything else unchanged
   function automatic logic [7:0] up_ascii(input logic [7:0] x);
      if (x inside {[8'h61:8'h7A]}) begin
         return x - 8'h20;
      end
      return x;
   endfunction

   // sequence length implied by a lead byte
   function automatic logic [2:0] seq_len(input logic [7:0] x);
      if (x[7:5] == 3'b110) return 3'd2;
      if (x[7:4] == 4'b1110) return 3'd3;
      if (x[7:3] == 5'b11110) return 3'd4;
      return 3'd1;
   endfunction

   // decode, uppercase and re-encode a two-byte sequence
   function automatic u8cu_pkg::pair_type enc_pair(input logic [7:0] lead,
                                                  input logic [7:0] trail);
      logic [10:0]        cp;
      u8cu_pkg::pair_type p;
      cp = {lead[4:0], trail[5:0]};
      if (cp inside {[u8cu_pkg::CP_SMALL_A:u8cu_pkg::CP_SMALL_YA]}) begin
         cp = cp - u8cu_pkg::CP_CASE_OFS;
      end else if (cp == u8cu_pkg::CP_SMALL_IO) begin
         cp = u8cu_pkg::CP_CAP_IO;
      end else if (cp == u8cu_pkg::CP_SMALL_I) begin
         cp = u8cu_pkg::CP_CAP_I;
      end else if (cp == u8cu_pkg::CP_SMALL_YI) begin
         cp = u8cu_pkg::CP_CAP_YI;
      end else if (cp == u8cu_pkg::CP_SMALL_YE) begin
         cp = u8cu_pkg::CP_CAP_YE;
      end else if (cp == u8cu_pkg::CP_SMALL_GHE) begin
         cp = u8cu_pkg::CP_CAP_GHE;
      end
      // overlong form collapses to one byte
      if (cp < u8cu_pkg::CP_ONE_BYTE) begin
         p.two = 1'b0;
         p.b0  = cp[7:0];
         p.b1  = cp[7:0];
      end else begin
         p.two = 1'b1;
         p.b0  = {3'b110, cp[10:6]};
         p.b1  = {2'b10, cp[5:0]};
      end
      return p;
   endfunction

   // held sequence state
   logic [7:0]  held_ff [3];
   logic [7:0]  held_in [3];
   logic [1:0]  held_n_ff, held_n_in;

   // output buffer, drained from entry 0
   logic [7:0]  buf_ff [u8cu_pkg::MAX_OUT];
   logic [7:0]  buf_in [u8cu_pkg::MAX_OUT];
   logic [2:0]  buf_n_ff, buf_n_in;
   logic        buf_last_ff, buf_last_in;

   logic [7:0]  res_b [u8cu_pkg::MAX_OUT];
   logic [2:0]  res_n;
   logic [2:0]  need;
   logic        accept, take;
   logic [7:0]  b;
   logic        last;
   u8cu_pkg::pair_type pair0, pair1;

   assign b         = req_data.data_byte;
   assign last      = req_data.is_last;
   assign rsp_valid = (buf_n_ff != 3'd0);
   assign take      = rsp_valid && rsp_ready;
   assign req_ready = (buf_n_ff == 3'd0) || ((buf_n_ff == 3'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign rsp_data.out_byte = buf_ff[0];
   assign rsp_data.out_last = buf_last_ff && (buf_n_ff == 3'd1);

   assign need  = seq_len(held_ff[0]);
   assign pair0 = enc_pair(held_ff[0], b);
   assign pair1 = enc_pair(held_ff[1], b);

   // result bytes and held-state update for the incoming request
   always_comb begin
      for (int i = 0; i < u8cu_pkg::MAX_OUT; i++) begin
         res_b[i]   = b;
      end
      for (int i = 0; i < 3; i++) begin
         held_in[i] = held_ff[i];
      end
      res_n     = 3'd0;
      held_n_in = held_n_ff;
      if (held_n_ff == 2'd0) begin
         if (!b[7] || (seq_len(b) == 3'd1) || last) begin
            res_b[0]  = up_ascii(b);
            res_n     = 3'd1;
         end else begin
            held_in[0] = b;
            held_n_in  = 2'd1;
         end
      end else if (({1'b0, held_n_ff} + 3'd1) >= need) begin
         // sequence complete
         held_n_in = 2'd0;
         if (need == 3'd2) begin
            res_b[0] = pair0.b0;
            res_b[1] = pair0.b1;
            res_n    = pair0.two ? 3'd2 : 3'd1;
         end else begin
            res_b[0] = held_ff[0];
            res_b[1] = held_ff[1];
            res_b[2] = (need == 3'd3) ? b : held_ff[2];
            res_b[3] = b;
            res_n    = need;
         end
      end else if (last) begin
         // string ends inside a sequence: lead passes, the rest is rescanned
         held_n_in = 2'd0;
         res_b[0]  = held_ff[0];
         if (held_n_ff == 2'd1) begin
            res_b[1] = up_ascii(b);
            res_n    = 3'd2;
         end else if (seq_len(held_ff[1]) == 3'd2) begin
            res_b[1] = pair1.b0;
            res_b[2] = pair1.b1;
            res_n    = pair1.two ? 3'd3 : 3'd2;
         end else begin
            res_b[1] = up_ascii(held_ff[1]);
            res_b[2] = up_ascii(b);
            res_n    = 3'd3;
         end
      end else begin
         held_in[held_n_ff] = b;
         held_n_in          = held_n_ff + 2'd1;
      end
   end

   // output buffer load and drain
   always_comb begin
      for (int i = 0; i < u8cu_pkg::MAX_OUT; i++) begin
         buf_in[i] = buf_ff[i];
      end
      buf_n_in    = buf_n_ff;
      buf_last_in = buf_last_ff;
      if (accept) begin
         for (int i = 0; i < u8cu_pkg::MAX_OUT; i++) begin
            buf_in[i] = res_b[i];
         end
         buf_n_in    = res_n;
         buf_last_in = last;
      end else if (take) begin
         for (int i = 0; i < u8cu_pkg::MAX_OUT - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         buf_n_in = buf_n_ff - 3'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_n_ff   <= 2'd0;
         buf_n_ff    <= 3'd0;
         buf_last_ff <= 1'b0;
      end else begin
         if (accept) begin
            held_n_ff <= held_n_in;
         end
         buf_n_ff    <= buf_n_in;
         buf_last_ff <= buf_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            held_ff[i] <= held_in[i];
         end
      end
      for (int i = 0; i < u8cu_pkg::MAX_OUT; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

endmodule

`default_nettype wire

@@ rtl/u8cu_checker.sv @@
`default_nettype none

module u8cu_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input u8cu_pkg::req_type  req_data,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input u8cu_pkg::rsp_type  rsp_data
);

   // a stalled response keeps its byte and flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no new request while the current response is stalled
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

   // the final byte of a string always produces output
   a_last_gives_output: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.is_last |=> rsp_valid)
      else $error("no output after final request");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind utf8_cyrillic_uppercase_stream_top u8cu_checker u_u8cu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 270;

   // Receiver behaviour
   typedef enum int unsigned {
      RX_ALWAYS,
      RX_CHOPPY,
      RX_LONG_STALL
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   u8cu_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   u8cu_pkg::rsp_type rsp_data;

   // Predictor state: held lead and following bytes of an open sequence
   logic [7:0] held [3];
   int unsigned held_n = 0;
   logic [7:0] step_bytes[$];
   u8cu_pkg::rsp_type upper_q[$];

   // String being built for the sender
   logic [7:0] text_q[$];

   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sent_count = 0;
   int unsigned burst_left = 0;
   int unsigned gap_max = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int unsigned stall_left = 0;

   utf8_cyrillic_uppercase_stream_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic int unsigned seq_len(logic [7:0] lead);
      if (lead[7:5] == 3'b110) return 2;
      if (lead[7:4] == 4'b1110) return 3;
      if (lead[7:3] == 5'b11110) return 4;
      return 1;
   endfunction

   function automatic void add_byte(logic [7:0] b);
      if (step_bytes.size() < u8cu_pkg::MAX_OUT) step_bytes.push_back(b);
   endfunction

   function automatic logic [10:0] capital_of(logic [10:0] cp);
      if (cp >= u8cu_pkg::CP_SMALL_A && cp <= u8cu_pkg::CP_SMALL_YA)
         return cp - u8cu_pkg::CP_CASE_OFS;
      if (cp == u8cu_pkg::CP_SMALL_IO) return u8cu_pkg::CP_CAP_IO;
      if (cp == u8cu_pkg::CP_SMALL_I) return u8cu_pkg::CP_CAP_I;
      if (cp == u8cu_pkg::CP_SMALL_YI) return u8cu_pkg::CP_CAP_YI;
      if (cp == u8cu_pkg::CP_SMALL_YE) return u8cu_pkg::CP_CAP_YE;
      if (cp == u8cu_pkg::CP_SMALL_GHE) return u8cu_pkg::CP_CAP_GHE;
      return cp;
   endfunction

   // Decode a two-byte pair, map it, re-encode (overlong forms fold to one byte)
   function automatic void add_pair(logic [7:0] lead, logic [7:0] trail);
      logic [10:0] cp;
      cp = capital_of({lead[4:0], trail[5:0]});
      if (cp < u8cu_pkg::CP_ONE_BYTE) begin
         add_byte(cp[7:0]);
      end else begin
         add_byte({3'b110, cp[10:6]});
         add_byte({2'b10, cp[5:0]});
      end
   endfunction

   // Work out the output bytes of one accepted request and queue them
   function automatic void predict_upper(logic [7:0] b, logic last);
      logic [7:0] work_b[$];
      logic work_l[$];
      logic [7:0] tail[$];
      logic [7:0] cur;
      logic cur_last;
      int unsigned need;
      u8cu_pkg::rsp_type r;
      step_bytes.delete();
      work_b.push_back(b);
      work_l.push_back(last);
      while (work_b.size() > 0) begin
         cur = work_b.pop_front();
         cur_last = work_l.pop_front();
         if (held_n == 0) begin
            if (cur < 8'h80) begin
               add_byte((cur >= 8'h61 && cur <= 8'h7A) ? cur - 8'h20 : cur);
            end else if (seq_len(cur) == 1 || cur_last) begin
               add_byte(cur);
            end else begin
               held[0] = cur;
               held_n = 1;
            end
         end else begin
            need = seq_len(held[0]);
            if (held_n + 1 >= need) begin
               if (need == 2) begin
                  add_pair(held[0], cur);
               end else begin
                  for (int i = 0; i < int'(held_n); i++) add_byte(held[i]);
                  add_byte(cur);
               end
               held_n = 0;
            end else if (cur_last) begin
               // string ends mid-sequence: lead out, rest re-run as a fresh string
               tail.delete();
               for (int i = 1; i < int'(held_n); i++) tail.push_back(held[i]);
               tail.push_back(cur);
               held_n = 0;
               add_byte(held[0]);
               for (int i = tail.size() - 1; i >= 0; i--) begin
                  work_b.push_front(tail[i]);
                  work_l.push_front(i == tail.size() - 1);
               end
            end else if (held_n < 3) begin
               held[held_n] = cur;
               held_n++;
            end
         end
      end
      if (last) held_n = 0;
      for (int i = 0; i < step_bytes.size(); i++) begin
         r.out_byte = step_bytes[i];
         r.out_last = last && (i == step_bytes.size() - 1);
         upper_q.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------
   // Receiver stall pattern
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      case (rx_mode)
         RX_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RX_CHOPPY: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (stall_left != 0) begin
               stall_left <= stall_left - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 8);
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Result checker and watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      u8cu_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (upper_q.size() == 0) begin
            $error("unexpected result: out_byte %h out_last %b",
                   rsp_data.out_byte, rsp_data.out_last);
            err_count++;
         end else begin
            want = upper_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               err_count++;
            end
            if (rsp_data.out_last !== want.out_last) begin
               $error("out_last: expected %b, got %b", want.out_last, rsp_data.out_last);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   task automatic idle_gap(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_byte(logic [7:0] b, logic last);
      u8cu_pkg::req_type r;
      if (burst_left == 0) begin
         idle_gap($urandom_range(0, gap_max));
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      r.data_byte = b;
      r.is_last = last;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_upper(b, last);
      sent_count++;
   endtask

   // Send the built string, flag on its final byte
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // Sender holds off until every queued result has been read
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (upper_q.size() != 0) @(posedge clock);
   endtask

   // Random token: mostly well-formed characters, some noise
   function automatic void add_token();
      logic [10:0] cp;
      case ($urandom_range(0, 9))
         0, 1: begin
            if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            else text_q.push_back(8'($urandom_range(0, 8'h7F)));
         end
         2, 3, 4: begin
            case ($urandom_range(0, 3))
               0, 1: cp = u8cu_pkg::CP_SMALL_A + 11'($urandom_range(0, 31));
               2: begin
                  case ($urandom_range(0, 5))
                     0: cp = u8cu_pkg::CP_SMALL_IO;
                     1: cp = u8cu_pkg::CP_SMALL_I;
                     2: cp = u8cu_pkg::CP_SMALL_YI;
                     3: cp = u8cu_pkg::CP_SMALL_YE;
                     4: cp = u8cu_pkg::CP_SMALL_GHE;
                     default: cp = 11'($urandom_range(11'h400, 11'h4FF));
                  endcase
               end
               default: cp = 11'($urandom_range(0, 11'h7FF));
            endcase
            text_q.push_back({3'b110, cp[10:6]});
            if ($urandom_range(0, 7) == 0) text_q.push_back(8'($urandom_range(0, 255)));
            else text_q.push_back({2'b10, cp[5:0]});
         end
         5: begin
            text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         6: begin
            text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         7: begin
            if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
         end
         8: text_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
         default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_ascii();
      rx_mode = RX_ALWAYS;
      gap_max = 0;
      text_q = '{8'h00, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'h7F};
      send_text();
   endtask

   task automatic test_cyrillic();
      rx_mode = RX_CHOPPY;
      gap_max = 2;
      // a, small io, small ghe, overlong 'a' left unmapped
      text_q = '{8'hD0, 8'hB0, 8'hD1, 8'h91, 8'hD2, 8'h91, 8'hC1, 8'hA1};
      send_text();
      // ya completing on the final byte
      text_q = '{8'hD1, 8'h8F};
      send_text();
   endtask

   task automatic test_stray_and_lead_last();
      rx_mode = RX_LONG_STALL;
      text_q = '{8'h80, 8'hFF, 8'hC3};
      send_text();
   endtask

   task automatic test_long_sequences();
      rx_mode = RX_LONG_STALL;
      gap_max = 3;
      // three-byte passes through, four-byte gives the widest burst
      text_q = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
      send_text();
   endtask

   task automatic test_truncated();
      rx_mode = RX_CHOPPY;
      // four-byte lead cut short; the two-byte pair behind it is re-run
      send_byte(8'hF0, 1'b0);
      send_byte(8'hD0, 1'b0);
      drain();
      send_byte(8'hB0, 1'b1);
      text_q = '{8'hF0, 8'h9F};
      send_text();
   endtask

   task automatic test_random_text();
      int unsigned start;
      start = sent_count;
      while (sent_count - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: rx_mode = RX_ALWAYS;
            1: rx_mode = RX_CHOPPY;
            default: rx_mode = RX_LONG_STALL;
         endcase
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat ($urandom_range(1, 5)) add_token();
         send_text();
         if ($urandom_range(0, 15) == 0) drain();
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_ascii();
      drain();
      test_cyrillic();
      test_stray_and_lead_last();
      drain();
      test_long_sequences();
      test_truncated();
      drain();
      test_random_text();
      drain();

      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/u8cu_pkg.sv
rtl/utf8_cyrillic_uppercase_stream_top.sv
rtl/u8cu_checker.sv
test/tb_top.sv
